FILE: hw/rtl/ptsb_pkg.sv
package ptsb_pkg;

    localparam int NUM_BINS     = 16384;
    localparam int CORDIC_STEPS = 18;

    localparam int BIN_W      = $clog2(NUM_BINS);
    localparam int CI_W       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int CNT_W      = 5;
    localparam int COORD_W    = 20;
    localparam int ANG_W      = 19;
    localparam int STEP_W     = 18;
    localparam int DIST_W     = 20;
    localparam int BINO_W     = 14;
    localparam int STAT_W     = 3;
    localparam int SQ_W       = 41;
    localparam int SQRT_LAST  = 20;
    localparam int DIV_W      = 20;
    localparam int CORDIC_W   = 48;
    localparam int CORDIC_SH  = 24;
    localparam int ZACC_W     = 36;
    localparam int ANGO_W     = 20;
    localparam int APB_AW     = 5;

    // register indexes
    localparam logic [2:0] REG_HEIGHT_LOW  = 3'd0;
    localparam logic [2:0] REG_HEIGHT_HIGH = 3'd1;
    localparam logic [2:0] REG_HANGLE_LOW  = 3'd2;
    localparam logic [2:0] REG_HANGLE_HIGH = 3'd3;
    localparam logic [2:0] REG_HANGLE_STEP = 3'd4;
    localparam logic [2:0] REG_VANGLE_LOW  = 3'd5;
    localparam logic [2:0] REG_VANGLE_HIGH = 3'd6;
    localparam logic [2:0] REG_MIN_DIST    = 3'd7;

    localparam logic signed [COORD_W-1:0] RST_HEIGHT_LOW  = -20'sd1000;
    localparam logic signed [COORD_W-1:0] RST_HEIGHT_HIGH = 20'sd1000;
    localparam logic signed [ANG_W-1:0]   RST_HANGLE_LOW  = -19'sd205887;
    localparam logic signed [ANG_W-1:0]   RST_HANGLE_HIGH = 19'sd205887;
    localparam logic [STEP_W-1:0]         RST_HANGLE_STEP = 18'd36;
    localparam logic signed [ANG_W-1:0]   RST_VANGLE_LOW  = -19'sd114;
    localparam logic signed [ANG_W-1:0]   RST_VANGLE_HIGH = 19'sd114;
    localparam logic [DIST_W-1:0]         RST_MIN_DIST    = 20'd500;

    localparam logic CMD_BIN  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 3'd0,
        STAT_HEIGHT = 3'd1,
        STAT_NEAR   = 3'd2,
        STAT_VANG   = 3'd3,
        STAT_HANG   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OUT_POINT  = 2'd0,
        OUT_REJECT = 2'd1,
        OUT_READ   = 2'd2
    } out_kind_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] height_low;
        logic signed [COORD_W-1:0] height_high;
        logic signed [ANG_W-1:0]   hangle_low;
        logic signed [ANG_W-1:0]   hangle_high;
        logic [STEP_W-1:0]         hangle_step;
        logic signed [ANG_W-1:0]   vangle_low;
        logic signed [ANG_W-1:0]   vangle_high;
        logic [DIST_W-1:0]         min_distance;
    } cfg_t;

    typedef struct packed {
        logic      accept;
        logic      mul_x;
        logic      mul_y;
        logic      sqrt_init;
        logic      sqrt_step;
        logic      cordic_load;
        logic      cordic_vert;
        logic      cordic_step;
        logic      div_init;
        logic      div_step;
        logic      calc_idx;
        logic      rd_bin;
        logic      rd_point;
        logic      save_read;
        logic      save_point;
        logic      clr_step;
        logic      load_out;
        out_kind_t kind;
        status_t   code;
    } ptsb_cmd_t;

    typedef struct packed {
        logic is_read;
        logic cnt_last;
        logic clr_last;
        logic height_fail;
        logic near_fail;
        logic vang_fail;
        logic hang_fail;
    } ptsb_sts_t;

    typedef logic signed [ZACC_W-1:0] atan_tab_t [CORDIC_STEPS];

    // unsigned quotient by shift and subtract, elaboration only
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            r = (r << 1) | ((num >> b) & 64'd1);
            if (r >= den) begin
                r = r - den;
                q = q | (64'd1 << b);
            end
        end
        return q;
    endfunction

    // atan(1/n) in units of 2^-40 rad by the alternating series, elaboration only
    function automatic longint unsigned atan_inv(input longint unsigned n);
        longint unsigned term;
        longint unsigned sum;
        longint unsigned nn;
        longint unsigned t;
        term = udiv64(64'd1 << 40, n);
        sum  = 0;
        nn   = n * n;
        for (int k = 0; k < 48; k++) begin
            if (term != 0) begin
                t = udiv64(term, 64'(2 * k + 1));
                if (k[0] == 1'b0) begin
                    sum = sum + t;
                end else begin
                    sum = sum - t;
                end
                term = udiv64(term, nn);
            end
        end
        return sum;
    endfunction

    function automatic atan_tab_t build_atan_tab();
        atan_tab_t       tab;
        longint unsigned a;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (i == 0) begin
                a = atan_inv(64'd2) + atan_inv(64'd3);
            end else begin
                a = atan_inv(64'd1 << i);
            end
            tab[i] = ZACC_W'((a + 64'd128) >> 8);
        end
        return tab;
    endfunction

    function automatic longint unsigned calc_half_pi();
        longint unsigned a1;
        a1 = atan_inv(64'd2) + atan_inv(64'd3);
        return (2 * a1 + 64'd128) >> 8;
    endfunction

    localparam atan_tab_t ATAN_TAB = build_atan_tab();
    localparam logic signed [ZACC_W-1:0] HALF_PI = ZACC_W'(calc_half_pi());

endpackage

FILE: hw/rtl/ptsb_ctrl.sv
module ptsb_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  ptsb_pkg::ptsb_sts_t sts,
    output ptsb_pkg::ptsb_cmd_t cmd
);

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_MUL_Y,
        S_SQ_INIT,
        S_SQRT,
        S_CHECK,
        S_CORDIC_V,
        S_CHECK_V,
        S_CORDIC_H,
        S_CHECK_H,
        S_DIV,
        S_IDX,
        S_MEM_RD,
        S_CMP,
        S_RD_DONE,
        S_DONE
    } state_t;

    state_t                   state_reg, state_next;
    logic                     m_valid_reg, m_valid_next;
    ptsb_pkg::out_kind_t      kind_reg, kind_next;
    ptsb_pkg::status_t        code_reg, code_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        code_next    = code_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        cmd.kind     = kind_reg;
        cmd.code     = code_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (sts.is_read) begin
                    cmd.rd_bin = 1'b1;
                    state_next = S_RD_DONE;
                end else begin
                    cmd.mul_x  = 1'b1;
                    state_next = S_MUL_Y;
                end
            end
            S_MUL_Y: begin
                cmd.mul_y  = 1'b1;
                state_next = S_SQ_INIT;
            end
            S_SQ_INIT: begin
                cmd.sqrt_init = 1'b1;
                state_next    = S_SQRT;
            end
            S_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (sts.cnt_last) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (sts.height_fail) begin
                    kind_next  = ptsb_pkg::OUT_REJECT;
                    code_next  = ptsb_pkg::STAT_HEIGHT;
                    state_next = S_DONE;
                end else if (sts.near_fail) begin
                    kind_next  = ptsb_pkg::OUT_REJECT;
                    code_next  = ptsb_pkg::STAT_NEAR;
                    state_next = S_DONE;
                end else begin
                    cmd.cordic_load = 1'b1;
                    cmd.cordic_vert = 1'b1;
                    state_next      = S_CORDIC_V;
                end
            end
            S_CORDIC_V: begin
                cmd.cordic_step = 1'b1;
                if (sts.cnt_last) begin
                    state_next = S_CHECK_V;
                end
            end
            S_CHECK_V: begin
                if (sts.vang_fail) begin
                    kind_next  = ptsb_pkg::OUT_REJECT;
                    code_next  = ptsb_pkg::STAT_VANG;
                    state_next = S_DONE;
                end else begin
                    cmd.cordic_load = 1'b1;
                    state_next      = S_CORDIC_H;
                end
            end
            S_CORDIC_H: begin
                cmd.cordic_step = 1'b1;
                if (sts.cnt_last) begin
                    state_next = S_CHECK_H;
                end
            end
            S_CHECK_H: begin
                if (sts.hang_fail) begin
                    kind_next  = ptsb_pkg::OUT_REJECT;
                    code_next  = ptsb_pkg::STAT_HANG;
                    state_next = S_DONE;
                end else begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.cnt_last) begin
                    state_next = S_IDX;
                end
            end
            S_IDX: begin
                cmd.calc_idx = 1'b1;
                state_next   = S_MEM_RD;
            end
            S_MEM_RD: begin
                cmd.rd_point = 1'b1;
                state_next   = S_CMP;
            end
            S_CMP: begin
                cmd.save_point = 1'b1;
                kind_next      = ptsb_pkg::OUT_POINT;
                code_next      = ptsb_pkg::STAT_OK;
                state_next     = S_DONE;
            end
            S_RD_DONE: begin
                cmd.save_read = 1'b1;
                kind_next     = ptsb_pkg::OUT_READ;
                code_next     = ptsb_pkg::STAT_OK;
                state_next    = S_DONE;
            end
            S_DONE: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
            kind_reg    <= ptsb_pkg::OUT_POINT;
            code_reg    <= ptsb_pkg::STAT_OK;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            kind_reg    <= kind_next;
            code_reg    <= code_next;
        end
    end

endmodule

FILE: hw/rtl/ptsb_dp.sv
module ptsb_dp (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  ptsb_pkg::cfg_t                         cfg,
    input  ptsb_pkg::ptsb_cmd_t                    cmd,
    output ptsb_pkg::ptsb_sts_t                    sts,
    input  logic                                   in_command,
    input  logic signed [ptsb_pkg::COORD_W-1:0]    in_x,
    input  logic signed [ptsb_pkg::COORD_W-1:0]    in_y,
    input  logic signed [ptsb_pkg::COORD_W-1:0]    in_z,
    input  logic [ptsb_pkg::BINO_W-1:0]            in_read_bin,
    output logic [ptsb_pkg::STAT_W-1:0]            out_status,
    output logic [ptsb_pkg::BINO_W-1:0]            out_bin_index,
    output logic [ptsb_pkg::DIST_W-1:0]            out_distance,
    output logic                                   out_updated
);

    localparam int CW = ptsb_pkg::CORDIC_W;
    localparam int ZW = ptsb_pkg::ZACC_W;
    localparam int BW = ptsb_pkg::BIN_W;

    // input word
    logic                                cmd_reg;
    logic signed [ptsb_pkg::COORD_W-1:0] x_reg, y_reg, z_reg;
    logic [ptsb_pkg::BINO_W-1:0]         rbin_reg;

    // range
    logic [ptsb_pkg::SQ_W-1:0]           sq_reg, root_reg;
    logic signed [2*ptsb_pkg::COORD_W-1:0] prod;
    logic signed [ptsb_pkg::COORD_W-1:0] mul_in;
    logic [ptsb_pkg::SQ_W-1:0]           sq_bit, sq_trial;
    logic [ptsb_pkg::DIST_W-1:0]         range;

    logic [ptsb_pkg::CNT_W-1:0]          cnt_reg;

    // cordic
    logic signed [CW-1:0]                cx_reg, cy_reg;
    logic signed [ZW-1:0]                cz_reg;
    logic                                zero_reg;
    logic signed [ptsb_pkg::DIST_W:0]    src_x, src_y;
    logic signed [CW-1:0]                ld_x, ld_y, dx, dy;
    logic [ptsb_pkg::CNT_W-1:0]          sh;
    logic signed [ZW-1:0]                atan_val, z_round;
    logic signed [ptsb_pkg::ANGO_W-1:0]  ang;

    // divider
    logic [ptsb_pkg::DIV_W-1:0]          dq_reg;
    logic [ptsb_pkg::STEP_W-1:0]         rem_reg, step_eff;
    logic [ptsb_pkg::STEP_W:0]           partial;
    logic                                hh_hit_reg;
    logic signed [ptsb_pkg::ANGO_W:0]    ang_off;
    logic signed [ptsb_pkg::ANG_W:0]     span;
    logic [ptsb_pkg::DIV_W-1:0]          idx_full;
    logic [BW-1:0]                       idx_reg;

    // bin memory
    logic [ptsb_pkg::DIST_W-1:0]         mem [ptsb_pkg::NUM_BINS];
    logic [ptsb_pkg::DIST_W-1:0]         mem_q_reg, mem_wdata;
    logic [BW-1:0]                       mem_raddr, mem_waddr, addr_reg, clr_reg, rbin_addr;
    logic                                mem_re, mem_we, rd_in_range;
    logic                                upd_reg;
    logic [ptsb_pkg::DIST_W-1:0]         bin_val_reg;

    assign range     = root_reg[ptsb_pkg::DIST_W-1:0];
    assign mul_in    = cmd.mul_x ? x_reg : y_reg;
    assign prod      = mul_in * mul_in;
    assign sq_bit    = ptsb_pkg::SQ_W'(1) << {cnt_reg, 1'b0};
    assign sq_trial  = root_reg + sq_bit;

    // cordic source and quadrant pre-rotation for x < 0
    assign src_x = cmd.cordic_vert ? $signed({1'b0, range}) : (ptsb_pkg::DIST_W + 1)'(x_reg);
    assign src_y = cmd.cordic_vert ? (ptsb_pkg::DIST_W + 1)'(z_reg) : (ptsb_pkg::DIST_W + 1)'(y_reg);
    assign ld_x  = CW'(src_x) <<< ptsb_pkg::CORDIC_SH;
    assign ld_y  = CW'(src_y) <<< ptsb_pkg::CORDIC_SH;

    assign sh       = ptsb_pkg::CNT_W'(ptsb_pkg::CORDIC_STEPS - 1) - cnt_reg;
    assign dx       = cy_reg >>> sh;
    assign dy       = cx_reg >>> sh;
    assign atan_val = ptsb_pkg::ATAN_TAB[ptsb_pkg::CI_W'(sh)];
    assign z_round  = cz_reg + ZW'(32768);
    assign ang      = zero_reg ? '0 : z_round[ZW-1:16];

    assign step_eff = (cfg.hangle_step == '0) ? ptsb_pkg::STEP_W'(1) : cfg.hangle_step;
    assign partial  = {rem_reg, dq_reg[ptsb_pkg::DIV_W-1]};
    assign ang_off  = (ptsb_pkg::ANGO_W + 1)'(ang) - (ptsb_pkg::ANGO_W + 1)'(cfg.hangle_low);
    assign span     = (ptsb_pkg::ANG_W + 1)'(cfg.hangle_high) - (ptsb_pkg::ANG_W + 1)'(cfg.hangle_low);
    // an angle exactly on the upper limit falls into the last bin
    assign idx_full = (span > 0) ?
                      (dq_reg - ptsb_pkg::DIV_W'(hh_hit_reg && (rem_reg == '0))) : '0;

    assign rbin_addr   = BW'(rbin_reg);
    assign rd_in_range = (32'(rbin_reg) < 32'(ptsb_pkg::NUM_BINS));
    assign mem_re      = cmd.rd_bin || cmd.rd_point;
    assign mem_raddr   = cmd.rd_bin ? rbin_addr : idx_reg;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = '0;
        if (cmd.clr_step) begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
        end else if (cmd.save_read) begin
            mem_we = rd_in_range;
        end else if (cmd.save_point) begin
            mem_we    = (range > mem_q_reg);
            mem_wdata = range;
        end
    end

    always_comb begin
        sts             = '0;
        sts.is_read     = (cmd_reg == ptsb_pkg::CMD_READ);
        sts.cnt_last    = (cnt_reg == '0);
        sts.clr_last    = (32'(clr_reg) == 32'(ptsb_pkg::NUM_BINS - 1));
        sts.height_fail = (z_reg > cfg.height_high) || (z_reg < cfg.height_low);
        sts.near_fail   = (range < cfg.min_distance);
        sts.vang_fail   = (ang < cfg.vangle_low) || (ang > cfg.vangle_high);
        sts.hang_fail   = (ang < cfg.hangle_low) || (ang > cfg.hangle_high);
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_q_reg <= mem[mem_raddr];
            addr_reg  <= mem_raddr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_reg <= clr_reg + BW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            cmd_reg  <= in_command;
            x_reg    <= in_x;
            y_reg    <= in_y;
            z_reg    <= in_z;
            rbin_reg <= in_read_bin;
        end

        if (cmd.mul_x) begin
            sq_reg <= ptsb_pkg::SQ_W'(unsigned'(prod));
        end
        if (cmd.mul_y) begin
            sq_reg <= sq_reg + ptsb_pkg::SQ_W'(unsigned'(prod));
        end

        // one result bit per cycle
        if (cmd.sqrt_init) begin
            root_reg <= '0;
            cnt_reg  <= ptsb_pkg::CNT_W'(ptsb_pkg::SQRT_LAST);
        end else if (cmd.sqrt_step) begin
            if (sq_reg >= sq_trial) begin
                sq_reg   <= sq_reg - sq_trial;
                root_reg <= (root_reg >> 1) + sq_bit;
            end else begin
                root_reg <= root_reg >> 1;
            end
            cnt_reg <= cnt_reg - ptsb_pkg::CNT_W'(1);
        end

        if (cmd.cordic_load) begin
            zero_reg <= (src_x == '0) && (src_y == '0);
            cnt_reg  <= ptsb_pkg::CNT_W'(ptsb_pkg::CORDIC_STEPS - 1);
            if (src_x < 0) begin
                if (src_y >= 0) begin
                    cx_reg <= ld_y;
                    cy_reg <= -ld_x;
                    cz_reg <= ptsb_pkg::HALF_PI;
                end else begin
                    cx_reg <= -ld_y;
                    cy_reg <= ld_x;
                    cz_reg <= -ptsb_pkg::HALF_PI;
                end
            end else begin
                cx_reg <= ld_x;
                cy_reg <= ld_y;
                cz_reg <= '0;
            end
        end else if (cmd.cordic_step) begin
            if (cy_reg > 0) begin
                cx_reg <= cx_reg + dx;
                cy_reg <= cy_reg - dy;
                cz_reg <= cz_reg + atan_val;
            end else begin
                cx_reg <= cx_reg - dx;
                cy_reg <= cy_reg + dy;
                cz_reg <= cz_reg - atan_val;
            end
            cnt_reg <= cnt_reg - ptsb_pkg::CNT_W'(1);
        end

        // restoring divide of the angle offset by the bin width
        if (cmd.div_init) begin
            dq_reg     <= ang_off[ptsb_pkg::DIV_W-1:0];
            rem_reg    <= '0;
            hh_hit_reg <= (ang == cfg.hangle_high);
            cnt_reg    <= ptsb_pkg::CNT_W'(ptsb_pkg::DIV_W - 1);
        end else if (cmd.div_step) begin
            if (partial >= {1'b0, step_eff}) begin
                rem_reg <= ptsb_pkg::STEP_W'(partial - {1'b0, step_eff});
                dq_reg  <= {dq_reg[ptsb_pkg::DIV_W-2:0], 1'b1};
            end else begin
                rem_reg <= partial[ptsb_pkg::STEP_W-1:0];
                dq_reg  <= {dq_reg[ptsb_pkg::DIV_W-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg - ptsb_pkg::CNT_W'(1);
        end

        if (cmd.calc_idx) begin
            if (32'(idx_full) > 32'(ptsb_pkg::NUM_BINS - 1)) begin
                idx_reg <= BW'(ptsb_pkg::NUM_BINS - 1);
            end else begin
                idx_reg <= BW'(idx_full);
            end
        end

        if (cmd.save_point) begin
            upd_reg <= (range > mem_q_reg);
        end
        if (cmd.save_read) begin
            bin_val_reg <= rd_in_range ? mem_q_reg : '0;
        end

        if (cmd.load_out) begin
            case (cmd.kind)
                ptsb_pkg::OUT_POINT: begin
                    out_status    <= ptsb_pkg::STAT_OK;
                    out_bin_index <= ptsb_pkg::BINO_W'(idx_reg);
                    out_distance  <= range;
                    out_updated   <= upd_reg;
                end
                ptsb_pkg::OUT_READ: begin
                    out_status    <= ptsb_pkg::STAT_OK;
                    out_bin_index <= rbin_reg;
                    out_distance  <= bin_val_reg;
                    out_updated   <= 1'b0;
                end
                default: begin
                    out_status    <= cmd.code;
                    out_bin_index <= '0;
                    out_distance  <= range;
                    out_updated   <= 1'b0;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/point_to_scan_binner_top.sv
// point to scan binner: takes 3d points (x, y, z in signed mm) and folds them into a
// planar range scan of NUM_BINS bins, each bin keeping the largest planar range seen.
// a point is checked for height band, minimum range, vertical angle and horizontal
// angle, in that order; the first failed check is reported in m_status. a word with
// s_command = 1 reads one bin, returns its stored range and clears it to zero.
// operation: one word is processed at a time. a point passes through the squares, the
// bit-serial square root, two cordic atan2 passes (one shared unit), the bit-serial bin
// divider, the checks and the read-modify-write of the bin memory; rejected points
// finish early. the result sits in an output register, so the next word is taken
// while the previous result waits for m_ready. after reset the bin memory is cleared
// one entry per cycle, all NUM_BINS (16384) entries, with s_ready low.
// configuration: apb-style port, register i at byte address 4*i, pready always high.
module point_to_scan_binner_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ptsb_pkg::APB_AW-1:0]         paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    // input words
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_command,
    input  logic signed [ptsb_pkg::COORD_W-1:0] s_x_coord,
    input  logic signed [ptsb_pkg::COORD_W-1:0] s_y_coord,
    input  logic signed [ptsb_pkg::COORD_W-1:0] s_z_coord,
    input  logic [ptsb_pkg::BINO_W-1:0]         s_read_bin,
    // result words
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ptsb_pkg::STAT_W-1:0]         m_status,
    output logic [ptsb_pkg::BINO_W-1:0]         m_bin_index,
    output logic [ptsb_pkg::DIST_W-1:0]         m_distance,
    output logic                                m_updated
);

    ptsb_pkg::cfg_t      cfg_reg;
    ptsb_pkg::ptsb_cmd_t cmd;
    ptsb_pkg::ptsb_sts_t sts;
    logic [2:0]          reg_idx;
    logic                wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    // register file, written on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.height_low   <= ptsb_pkg::RST_HEIGHT_LOW;
            cfg_reg.height_high  <= ptsb_pkg::RST_HEIGHT_HIGH;
            cfg_reg.hangle_low   <= ptsb_pkg::RST_HANGLE_LOW;
            cfg_reg.hangle_high  <= ptsb_pkg::RST_HANGLE_HIGH;
            cfg_reg.hangle_step  <= ptsb_pkg::RST_HANGLE_STEP;
            cfg_reg.vangle_low   <= ptsb_pkg::RST_VANGLE_LOW;
            cfg_reg.vangle_high  <= ptsb_pkg::RST_VANGLE_HIGH;
            cfg_reg.min_distance <= ptsb_pkg::RST_MIN_DIST;
        end else if (wr_en) begin
            case (reg_idx)
                ptsb_pkg::REG_HEIGHT_LOW:  cfg_reg.height_low   <= pwdata[19:0];
                ptsb_pkg::REG_HEIGHT_HIGH: cfg_reg.height_high  <= pwdata[19:0];
                ptsb_pkg::REG_HANGLE_LOW:  cfg_reg.hangle_low   <= pwdata[18:0];
                ptsb_pkg::REG_HANGLE_HIGH: cfg_reg.hangle_high  <= pwdata[18:0];
                ptsb_pkg::REG_HANGLE_STEP: cfg_reg.hangle_step  <= pwdata[17:0];
                ptsb_pkg::REG_VANGLE_LOW:  cfg_reg.vangle_low   <= pwdata[18:0];
                ptsb_pkg::REG_VANGLE_HIGH: cfg_reg.vangle_high  <= pwdata[18:0];
                ptsb_pkg::REG_MIN_DIST:    cfg_reg.min_distance <= pwdata[19:0];
                default: begin
                end
            endcase
        end
    end

    // readback, signed registers sign extended
    always_comb begin
        case (reg_idx)
            ptsb_pkg::REG_HEIGHT_LOW:  prdata = 32'(cfg_reg.height_low);
            ptsb_pkg::REG_HEIGHT_HIGH: prdata = 32'(cfg_reg.height_high);
            ptsb_pkg::REG_HANGLE_LOW:  prdata = 32'(cfg_reg.hangle_low);
            ptsb_pkg::REG_HANGLE_HIGH: prdata = 32'(cfg_reg.hangle_high);
            ptsb_pkg::REG_HANGLE_STEP: prdata = 32'(cfg_reg.hangle_step);
            ptsb_pkg::REG_VANGLE_LOW:  prdata = 32'(cfg_reg.vangle_low);
            ptsb_pkg::REG_VANGLE_HIGH: prdata = 32'(cfg_reg.vangle_high);
            ptsb_pkg::REG_MIN_DIST:    prdata = 32'(cfg_reg.min_distance);
            default:                   prdata = '0;
        endcase
    end

    // sequencer
    ptsb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // range, cordic, divider, bin memory and output register
    ptsb_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .cmd           (cmd),
        .sts           (sts),
        .in_command    (s_command),
        .in_x          (s_x_coord),
        .in_y          (s_y_coord),
        .in_z          (s_z_coord),
        .in_read_bin   (s_read_bin),
        .out_status    (m_status),
        .out_bin_index (m_bin_index),
        .out_distance  (m_distance),
        .out_updated   (m_updated)
    );

endmodule
